FILE: hw/rtl/hft_pkg.sv
// Shared types, constants and the hash step for the hashed flag table.
// Used by the hash front end, the table cells and the top level.
package hft_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 64;
  localparam int unsigned LIMIT_W = 7;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  localparam logic CMD_SET = 1'b0;
  localparam logic CMD_GET = 1'b1;

  localparam logic [1:0] OUTC_UPDATED  = 2'd0;
  localparam logic [1:0] OUTC_APPENDED = 2'd1;
  localparam logic [1:0] OUTC_MISS     = 2'd2;

  // A search request as it travels along the row of cells.
  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic        cmd;
    logic        set_val;
    logic        found;
    logic        appended;
    logic        rd_val;
  } hft_tok_t;

  function automatic logic [31:0] fnv_fold(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] x;
    x = h ^ {24'h000000, b};
    return x * FNV_PRIME;
  endfunction

endpackage

FILE: hw/rtl/hft_hash.sv
// Running FNV-1a hash over the bytes of one flag name.
// Depends on hft_pkg for the basis, the prime and the fold function.
module hft_hash (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step_en,
  input  logic        step_last,
  input  logic [7:0]  step_byte,
  output logic [31:0] hash_fold
);

  logic [31:0] run_r;
  logic [31:0] run_nxt;

  assign hash_fold = hft_pkg::fnv_fold(run_r, step_byte);

  always_comb begin
    run_nxt = run_r;
    if (step_en) begin
      // The last byte hands its hash on and the next name starts fresh.
      run_nxt = step_last ? hft_pkg::FNV_BASIS : hash_fold;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= hft_pkg::FNV_BASIS;
    end else begin
      run_r <= run_nxt;
    end
  end

endmodule

FILE: hw/rtl/hft_cell.sv
// One table entry: a stored hash and flag, plus one stage of the search row.
// Depends on hft_pkg for the request type and command codes.
module hft_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [CW-1:0]     count,
  input  logic              append_ok,
  input  hft_pkg::hft_tok_t tok_in,
  output hft_pkg::hft_tok_t tok_out
);

  logic [31:0]       hash_r;
  logic              val_r;
  logic              active;
  logic              is_tail;
  logic              match;
  logic              app;
  hft_pkg::hft_tok_t tok_r;
  hft_pkg::hft_tok_t tok_nxt;

  assign active  = CW'(IDX) < count;
  assign is_tail = CW'(IDX) == count;
  assign match   = tok_in.valid && active && !tok_in.found && (hash_r == tok_in.key);
  // Cells past the count never match, so a request reaching the tail cell
  // unfound has missed the whole table.
  assign app     = tok_in.valid && is_tail && !tok_in.found &&
                   (tok_in.cmd == hft_pkg::CMD_SET) && append_ok;

  always_comb begin
    tok_nxt = tok_in;
    if (match) begin
      tok_nxt.found  = 1'b1;
      tok_nxt.rd_val = val_r;
    end
    if (app) begin
      tok_nxt.appended = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (app) begin
      hash_r <= tok_in.key;
      val_r  <= tok_in.set_val;
    end else if (match && (tok_in.cmd == hft_pkg::CMD_SET)) begin
      val_r  <= tok_in.set_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

FILE: hw/rtl/hashed_flag_table_top.sv
// Hashed flag table: non-last bytes are taken one per cycle while the input is
// not stalled; a name's last byte starts a search that walks the row of
// MAX_ENTRIES cells one per cycle. The result is registered as the request
// leaves the row. Input stalls from the last byte until the request leaves the
// row (longer while an earlier result sits unread), so names do not overlap.
// Reset (synchronous, active low) empties the table and restores the limit
// to 64; stored entries are not cleared and need no clearing pass.
module hashed_flag_table_top #(
  parameter int unsigned MAX_ENTRIES = hft_pkg::MAX_ENTRIES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_cmd,
  input  logic [7:0]                   in_name_byte,
  input  logic                         in_name_last,
  input  logic                         in_set_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_flag_value,
  output logic                         out_hit,
  output logic [1:0]                   out_outcome,
  input  logic                         cfg_we,
  input  logic [hft_pkg::LIMIT_W-1:0]  cfg_wdata
);

  localparam int unsigned CW   = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CMPW = (CW > hft_pkg::LIMIT_W) ? CW : hft_pkg::LIMIT_W;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_WAIT   = 3'b010,
    ST_SEARCH = 3'b100
  } state_t;

  state_t                      state_r, state_nxt;
  logic [hft_pkg::LIMIT_W-1:0] limit_r;
  logic [CW-1:0]               count_r;
  logic [31:0]                 key_r;
  logic                        cmd_r;
  logic                        setv_r;
  logic                        out_valid_r;
  logic                        out_val_r;
  logic                        out_hit_r;
  logic [1:0]                  out_outc_r;
  logic                        in_acc;
  logic                        launch;
  logic                        append_ok;
  logic [31:0]                 hash_fold;
  hft_pkg::hft_tok_t           tok [MAX_ENTRIES+1];
  hft_pkg::hft_tok_t           exit_tok;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  // A search starts only with the output register empty, so it is free
  // when the request leaves the row.
  assign launch   = (state_r == ST_WAIT) && !out_valid_r;
  assign append_ok = CMPW'(count_r) < CMPW'(limit_r);

  hft_hash u_hash (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (in_acc),
    .step_last (in_name_last),
    .step_byte (in_name_byte),
    .hash_fold (hash_fold)
  );

  always_comb begin
    tok[0]          = '0;
    tok[0].valid    = launch;
    tok[0].key      = key_r;
    tok[0].cmd      = cmd_r;
    tok[0].set_val  = setv_r;
  end

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    hft_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .count     (count_r),
      .append_ok (append_ok),
      .tok_in    (tok[i]),
      .tok_out   (tok[i+1])
    );
  end

  assign exit_tok = tok[MAX_ENTRIES];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_name_last) state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (launch) state_nxt = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (exit_tok.valid) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      limit_r     <= hft_pkg::LIMIT_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) limit_r <= cfg_wdata;
      if (exit_tok.valid && exit_tok.appended) count_r <= count_r + CW'(1);
      if (exit_tok.valid) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_name_last) begin
      key_r  <= hash_fold;
      cmd_r  <= in_cmd;
      setv_r <= in_set_value;
    end
    if (exit_tok.valid) begin
      out_hit_r <= exit_tok.found;
      if (exit_tok.found) begin
        out_outc_r <= hft_pkg::OUTC_UPDATED;
        out_val_r  <= (exit_tok.cmd == hft_pkg::CMD_GET) ? exit_tok.rd_val
                                                         : exit_tok.set_val;
      end else if (exit_tok.appended) begin
        out_outc_r <= hft_pkg::OUTC_APPENDED;
        out_val_r  <= exit_tok.set_val;
      end else begin
        out_outc_r <= hft_pkg::OUTC_MISS;
        out_val_r  <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_flag_value = out_val_r;
  assign out_hit        = out_hit_r;
  assign out_outcome    = out_outc_r;

`ifndef SYNTH
  a_exit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    exit_tok.valid |-> !out_valid_r)
    else $error("search left the row while the output register was full");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMPW'(count_r) <= CMPW'(MAX_ENTRIES))
    else $error("entry count above table capacity");

  a_hit_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_hit_r) |-> (out_outc_r == hft_pkg::OUTC_UPDATED))
    else $error("hit reported with an outcome other than updated");

  a_search_exit: assert property (@(posedge clk) disable iff (!rst_n)
    exit_tok.valid |-> (state_r == ST_SEARCH))
    else $error("request left the row with no search in flight");
`endif

endmodule
